### rtl/im2col_padded_gather_address_gen_defines.svh
// Assertion macros shared by the im2col gather address generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef IM2COL_PADDED_GATHER_ADDRESS_GEN_DEFINES_SVH
`define IM2COL_PADDED_GATHER_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/i2cpg_pkg.sv
// Package for the im2col gather address generator: widths, CSR codes,
// shared structs and clamp helpers. No dependencies.
package i2cpg_pkg;

   localparam int MAX_DIM      = 256;
   localparam int MAX_CHANNELS = 64;
   localparam int KERNEL_W_DEF = 3;
   localparam int KERNEL_H_DEF = 3;

   localparam int STRIDE_W   = 4;
   localparam int DIM_W      = 9;
   localparam int NCH_W      = 7;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int IDX_W      = 23;
   localparam int POS_W      = $clog2(MAX_DIM);        // output row/col counters
   localparam int CHAN_W     = $clog2(MAX_CHANNELS);   // channel counter
   localparam int OFS_W      = $clog2(MAX_DIM);        // in-image offset
   localparam int PAD_W      = 11;                     // leading pad
   localparam int COORD_W    = 12;                     // padded input coordinate
   localparam int PLANE_W    = 2 * DIM_W - 1;          // in_width * in_height

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_H_STRIDE    = 3'd0,
      REG_V_STRIDE    = 3'd1,
      REG_OUT_WIDTH   = 3'd2,
      REG_OUT_HEIGHT  = 3'd3,
      REG_IN_CHANNELS = 3'd4,
      REG_IN_WIDTH    = 3'd5,
      REG_IN_HEIGHT   = 3'd6
   } csr_idx_type;

   // clamped view of the configuration
   typedef struct packed {
      logic [STRIDE_W-1:0] hs;
      logic [STRIDE_W-1:0] vs;
      logic [DIM_W-1:0]    ow;
      logic [DIM_W-1:0]    oh;
      logic [NCH_W-1:0]    nc;
      logic [DIM_W-1:0]    iw;
      logic [DIM_W-1:0]    ih;
   } dims_type;

   // one tap after the position stage
   typedef struct packed {
      logic             in_bounds;
      logic [OFS_W-1:0] dy;
      logic [OFS_W-1:0] dx;
      logic [IDX_W-1:0] chan_base;
      logic             window_last;
      logic             list_last;
   } tap_type;

   function automatic logic [STRIDE_W-1:0] clamp_stride(logic [STRIDE_W-1:0] v);
      if (v == '0) return STRIDE_W'(1);
      if (v > STRIDE_W'(8)) return STRIDE_W'(8);
      return v;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
      if (v == '0) return DIM_W'(1);
      if (int'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
      return v;
   endfunction

   function automatic logic [NCH_W-1:0] clamp_chan(logic [NCH_W-1:0] v);
      if (v == '0) return NCH_W'(1);
      if (int'(v) > MAX_CHANNELS) return NCH_W'(MAX_CHANNELS);
      return v;
   endfunction

endpackage

### rtl/i2cpg_walk.sv
// Loop counters, leading padding and tap position stage of the generator.
// Depends on i2cpg_pkg.
module i2cpg_walk #(
   parameter int KERNEL_W = i2cpg_pkg::KERNEL_W_DEF,
   parameter int KERNEL_H = i2cpg_pkg::KERNEL_H_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                restart,
   input  i2cpg_pkg::dims_type dims,
   output i2cpg_pkg::tap_type  tap
);

   localparam int TCW = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;
   localparam int TRW = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
   localparam int PW  = i2cpg_pkg::PAD_W;
   localparam int CW  = i2cpg_pkg::COORD_W;
   localparam int POS = i2cpg_pkg::POS_W;
   localparam int CHW = i2cpg_pkg::CHAN_W;
   localparam int IW  = i2cpg_pkg::IDX_W;
   localparam int DW  = i2cpg_pkg::DIM_W;
   localparam int OW  = i2cpg_pkg::OFS_W;

   function automatic logic [PW-1:0] lead_pad(logic [DW-1:0] outn, logic [3:0] stride,
                                               logic [4:0] kern, logic [DW-1:0] inn);
      logic [CW:0] span;
      logic [CW:0] diff;
      span = (CW+1)'(outn - DW'(1)) * (CW+1)'(stride) + (CW+1)'(kern);
      if (span < (CW+1)'(inn)) return '0;
      diff = span - (CW+1)'(inn);
      return diff[PW:1];
   endfunction

   logic [POS-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [CHW-1:0] chan_ff, chan_in;
   logic [TRW-1:0] tap_row_ff, tap_row_in;
   logic [TCW-1:0] tap_col_ff, tap_col_in;
   logic [IW-1:0]  chan_base_ff, chan_base_in;
   logic [PW-1:0]  pad_left_ff, pad_left_in, pad_top_ff, pad_top_in;
   i2cpg_pkg::tap_type tap_ff, tap_in;

   logic [POS-1:0] cur_row, cur_col;
   logic [CHW-1:0] cur_chan;
   logic [TRW-1:0] cur_tr;
   logic [TCW-1:0] cur_tc;
   logic [IW-1:0]  cur_cb;
   logic [PW-1:0]  pad_l, pad_t;
   logic [CW-1:0]  iy, ix;
   logic           in_y, in_x;
   logic           tc_wrap, tr_wrap, ch_wrap, oc_wrap, or_wrap;
   logic [2*DW-2:0] plane;

   always_comb begin
      // restart zeroes the position before the current element is formed
      cur_row  = restart ? '0 : out_row_ff;
      cur_col  = restart ? '0 : out_col_ff;
      cur_chan = restart ? '0 : chan_ff;
      cur_tr   = restart ? '0 : tap_row_ff;
      cur_tc   = restart ? '0 : tap_col_ff;
      cur_cb   = restart ? '0 : chan_base_ff;
      pad_l    = restart ? lead_pad(dims.ow, dims.hs, 5'(KERNEL_W), dims.iw) : pad_left_ff;
      pad_t    = restart ? lead_pad(dims.oh, dims.vs, 5'(KERNEL_H), dims.ih) : pad_top_ff;
      pad_left_in = pad_l;
      pad_top_in  = pad_t;

      iy = CW'(cur_row) * CW'(dims.vs) + CW'(cur_tr);
      ix = CW'(cur_col) * CW'(dims.hs) + CW'(cur_tc);
      in_y = (iy >= CW'(pad_t)) && ((CW+1)'(iy) < (CW+1)'(pad_t) + (CW+1)'(dims.ih));
      in_x = (ix >= CW'(pad_l)) && ((CW+1)'(ix) < (CW+1)'(pad_l) + (CW+1)'(dims.iw));

      // nested counter carries
      tc_wrap = ((TCW+1)'(cur_tc) + (TCW+1)'(1)) >= (TCW+1)'(KERNEL_W);
      tr_wrap = tc_wrap && (((TRW+1)'(cur_tr) + (TRW+1)'(1)) >= (TRW+1)'(KERNEL_H));
      ch_wrap = tr_wrap && (((CHW+1)'(cur_chan) + (CHW+1)'(1)) >= (CHW+1)'(dims.nc));
      oc_wrap = ch_wrap && (((POS+1)'(cur_col) + (POS+1)'(1)) >= (POS+1)'(dims.ow));
      or_wrap = oc_wrap && (((POS+1)'(cur_row) + (POS+1)'(1)) >= (POS+1)'(dims.oh));

      plane = (2*DW-1)'(dims.iw) * (2*DW-1)'(dims.ih);

      tap_col_in = tc_wrap ? '0 : cur_tc + TCW'(1);
      tap_row_in = !tc_wrap ? cur_tr : (tr_wrap ? '0 : cur_tr + TRW'(1));
      chan_in    = !tr_wrap ? cur_chan : (ch_wrap ? '0 : cur_chan + CHW'(1));
      chan_base_in = !tr_wrap ? cur_cb : (ch_wrap ? '0 : cur_cb + IW'(plane));
      out_col_in = !ch_wrap ? cur_col : (oc_wrap ? '0 : cur_col + POS'(1));
      out_row_in = !oc_wrap ? cur_row : (or_wrap ? '0 : cur_row + POS'(1));

      tap_in.in_bounds   = in_y && in_x;
      tap_in.dy          = OW'(iy - CW'(pad_t));
      tap_in.dx          = OW'(ix - CW'(pad_l));
      tap_in.chan_base   = cur_cb;
      tap_in.window_last = ch_wrap;
      tap_in.list_last   = or_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         chan_ff      <= '0;
         tap_row_ff   <= '0;
         tap_col_ff   <= '0;
         chan_base_ff <= '0;
         pad_left_ff  <= '0;
         pad_top_ff   <= '0;
      end else if (load) begin
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         chan_ff      <= chan_in;
         tap_row_ff   <= tap_row_in;
         tap_col_ff   <= tap_col_in;
         chan_base_ff <= chan_base_in;
         pad_left_ff  <= pad_left_in;
         pad_top_ff   <= pad_top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tap_ff <= tap_in;
      end
   end

   assign tap = tap_ff;

endmodule

### rtl/im2col_padded_gather_address_gen.sv
// Top level of the im2col gather address generator for padded 2-D convolution.
// Depends on i2cpg_pkg, i2cpg_walk and im2col_padded_gather_address_gen_defines.svh.
//
// Usage:
//  - req channel (valid/ready): each transfer carries req_restart. 1 restarts the
//    list, recomputing the leading padding from the CSRs; 0 steps to the next tap.
//  - rsp channel (valid/ready): one transfer per request with the gather index
//    (0 for a padding tap, else the 1-based flat offset), window and list ends.
//  - csr port: write-only, csr_we/csr_index/csr_wdata, one register per cycle.
//    Write only while no request is in flight. Loop bounds apply at once; the
//    padding is captured at the next restart.
//  - Pipeline: two register stages (tap position, then address); a request's
//    response turns valid once the address stage has taken it.
//  - Throughput: one transfer per cycle while rsp_ready stays high. The position
//    stage (one small multiply per axis plus compares) and the address stage
//    (one 8x9 multiply plus a 23-bit add) are each computed combinationally.
//  - Stall: when rsp_ready is low the response holds; the position stage still
//    takes one more request, then req_ready drops until the response moves.
//  - Reset: CSRs go to 1, all loop counters and padding to 0, both stages empty.
`include "im2col_padded_gather_address_gen_defines.svh"

module im2col_padded_gather_address_gen #(
   parameter int KERNEL_W = i2cpg_pkg::KERNEL_W_DEF,
   parameter int KERNEL_H = i2cpg_pkg::KERNEL_H_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [i2cpg_pkg::IDX_W-1:0]           rsp_gather_index,
   output logic                                  rsp_window_last,
   output logic                                  rsp_list_last,
   input  logic                                  csr_we,
   input  logic [i2cpg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [i2cpg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IW  = i2cpg_pkg::IDX_W;
   localparam int SW  = i2cpg_pkg::STRIDE_W;
   localparam int DW  = i2cpg_pkg::DIM_W;
   localparam int NW  = i2cpg_pkg::NCH_W;
   localparam int PRW = i2cpg_pkg::OFS_W + DW;

   // ---------------- CSRs ----------------
   logic [SW-1:0] h_stride_ff, v_stride_ff;
   logic [DW-1:0] out_width_ff, out_height_ff, in_width_ff, in_height_ff;
   logic [NW-1:0] in_channels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_stride_ff    <= SW'(1);
         v_stride_ff    <= SW'(1);
         out_width_ff   <= DW'(1);
         out_height_ff  <= DW'(1);
         in_channels_ff <= NW'(1);
         in_width_ff    <= DW'(1);
         in_height_ff   <= DW'(1);
      end else if (csr_we) begin
         case (i2cpg_pkg::csr_idx_type'(csr_index))
            i2cpg_pkg::REG_H_STRIDE:    h_stride_ff    <= csr_wdata[SW-1:0];
            i2cpg_pkg::REG_V_STRIDE:    v_stride_ff    <= csr_wdata[SW-1:0];
            i2cpg_pkg::REG_OUT_WIDTH:   out_width_ff   <= csr_wdata[DW-1:0];
            i2cpg_pkg::REG_OUT_HEIGHT:  out_height_ff  <= csr_wdata[DW-1:0];
            i2cpg_pkg::REG_IN_CHANNELS: in_channels_ff <= csr_wdata[NW-1:0];
            i2cpg_pkg::REG_IN_WIDTH:    in_width_ff    <= csr_wdata[DW-1:0];
            i2cpg_pkg::REG_IN_HEIGHT:   in_height_ff   <= csr_wdata[DW-1:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // out-of-range values are clamped at use, the stored value is kept as written
   i2cpg_pkg::dims_type dims;
   always_comb begin
      dims.hs = i2cpg_pkg::clamp_stride(h_stride_ff);
      dims.vs = i2cpg_pkg::clamp_stride(v_stride_ff);
      dims.ow = i2cpg_pkg::clamp_dim(out_width_ff);
      dims.oh = i2cpg_pkg::clamp_dim(out_height_ff);
      dims.nc = i2cpg_pkg::clamp_chan(in_channels_ff);
      dims.iw = i2cpg_pkg::clamp_dim(in_width_ff);
      dims.ih = i2cpg_pkg::clamp_dim(in_height_ff);
   end

   // ---------------- flow control ----------------
   // stage A: tap position (i2cpg_walk), stage B: response register
   logic pos_vld_ff, pos_vld_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free, rsp_load, req_fire;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = pos_vld_ff && rsp_free;
   assign req_ready = !pos_vld_ff || rsp_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      pos_vld_in   = req_fire ? 1'b1 : (rsp_load ? 1'b0 : pos_vld_ff);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_vld_ff   <= pos_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- stage A: loop walk ----------------
   i2cpg_pkg::tap_type tap;

   i2cpg_walk #(
      .KERNEL_W (KERNEL_W),
      .KERNEL_H (KERNEL_H)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .load    (req_fire),
      .restart (req_restart),
      .dims    (dims),
      .tap     (tap)
   );

   // ---------------- stage B: flat address ----------------
   logic [PRW-1:0] row_ofs;
   logic [IW-1:0]  gather_index_ff, gather_index_in;
   logic           window_last_ff, list_last_ff;

   always_comb begin
      row_ofs = PRW'(tap.dy) * PRW'(dims.iw);
      // 23-bit wrap is the offset mask
      gather_index_in = tap.in_bounds
                        ? tap.chan_base + IW'(row_ofs) + IW'(tap.dx) + IW'(1)
                        : '0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         gather_index_ff <= gather_index_in;
         window_last_ff  <= tap.window_last;
         list_last_ff    <= tap.list_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gather_index = gather_index_ff;
   assign rsp_window_last  = window_last_ff;
   assign rsp_list_last    = list_last_ff;

   // ---------------- assertions ----------------
   `I2CPG_ASSERT_NOW(a_list_end_closes_window, clock, reset, rsp_valid && rsp_list_last, rsp_window_last, "list end without window end")
   `I2CPG_ASSERT_NEXT(a_pad_tap_zero, clock, reset, rsp_load && !tap.in_bounds, rsp_gather_index == '0, "padding tap gave nonzero index")
   `I2CPG_ASSERT_NEXT(a_image_tap_nonzero, clock, reset, rsp_load && tap.in_bounds, rsp_gather_index != '0, "image tap gave zero index")
   `I2CPG_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_valid_ff, req_ready, "request stalled with empty response stage")

endmodule
